// ===== design/aabb_collision_resolver_core_defines.svh =====
// Assertion macros for the box collision resolver.
// Stands alone; included by the files that carry assertions.
`ifndef AABB_COLLISION_RESOLVER_CORE_DEFINES_SVH
`define AABB_COLLISION_RESOLVER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define AABB_CR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("aabb_cr: assertion failed");
`define AABB_CR_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("aabb_cr: assertion failed");
`else
`define AABB_CR_ASSERT(label, clk, rst_n, prop)
`define AABB_CR_ASSERT_NR(label, clk, prop)
`endif
`endif

// ===== design/aabb_cr_pkg.sv =====
// Shared types and constants of the box collision resolver.
// No dependencies; imported by the interfaces and all modules.
package aabb_cr_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int SKIN_BITS      = 8;

    // Skin default is 0.03 in fixed point, rounded; bounce default is -100.
    localparam int SKIN_NUM     = 3;
    localparam int SKIN_DEN     = 100;
    localparam int BOUNCE_SPEED = 100;

    typedef enum logic [0:0] {
        OP_LOAD   = 1'b0,
        OP_STATIC = 1'b1
    } t_opcode;

    typedef enum logic [0:0] {
        CFG_SKIN_WIDTH = 1'b0,
        CFG_BOUNCE_VEL = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic right;
        logic left;
        logic up;
        logic down;
    } t_flags;

endpackage

// ===== design/aabb_cr_in_if.sv =====
// Input channel of the box collision resolver: valid, ready and one item.
// Depends on aabb_cr_pkg.
interface aabb_cr_in_if
    import aabb_cr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    t_opcode                      opcode;
    logic signed [COORD_BITS-1:0] box_min_x;
    logic signed [COORD_BITS-1:0] box_min_y;
    logic signed [COORD_BITS-1:0] box_max_x;
    logic signed [COORD_BITS-1:0] box_max_y;
    logic signed [COORD_BITS-1:0] load_vel_x;
    logic signed [COORD_BITS-1:0] load_vel_y;

    modport source (
        output valid, opcode, box_min_x, box_min_y, box_max_x, box_max_y,
               load_vel_x, load_vel_y,
        input  ready
    );
    modport sink (
        input  valid, opcode, box_min_x, box_min_y, box_max_x, box_max_y,
               load_vel_x, load_vel_y,
        output ready
    );
endinterface

// ===== design/aabb_cr_out_if.sv =====
// Result channel of the box collision resolver: valid, ready and one result.
// Depends on aabb_cr_pkg.
interface aabb_cr_out_if
    import aabb_cr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] out_min_x;
    logic signed [COORD_BITS-1:0] out_min_y;
    logic signed [COORD_BITS-1:0] out_max_x;
    logic signed [COORD_BITS-1:0] out_max_y;
    logic signed [COORD_BITS-1:0] out_vel_x;
    logic signed [COORD_BITS-1:0] out_vel_y;
    logic                         touch_down;
    logic                         touch_up;
    logic                         touch_left;
    logic                         touch_right;
    logic                         collided;

    modport source (
        output valid, out_min_x, out_min_y, out_max_x, out_max_y, out_vel_x,
               out_vel_y, touch_down, touch_up, touch_left, touch_right, collided,
        input  ready
    );
    modport sink (
        input  valid, out_min_x, out_min_y, out_max_x, out_max_y, out_vel_x,
               out_vel_y, touch_down, touch_up, touch_left, touch_right, collided,
        output ready
    );
endinterface

// ===== design/aabb_cr_push.sv =====
// Overlap test and minimum-translation push-out of the moving box.
// Depends on aabb_cr_pkg.
module aabb_cr_push
    import aabb_cr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic signed [COORD_BITS-1:0] i_mv_min_x,
    input  logic signed [COORD_BITS-1:0] i_mv_min_y,
    input  logic signed [COORD_BITS-1:0] i_mv_max_x,
    input  logic signed [COORD_BITS-1:0] i_mv_max_y,
    input  logic signed [COORD_BITS-1:0] i_mv_vel_x,
    input  logic signed [COORD_BITS-1:0] i_mv_vel_y,
    input  logic signed [COORD_BITS-1:0] i_box_min_x,
    input  logic signed [COORD_BITS-1:0] i_box_min_y,
    input  logic signed [COORD_BITS-1:0] i_box_max_x,
    input  logic signed [COORD_BITS-1:0] i_box_max_y,
    input  logic signed [COORD_BITS-1:0] i_bounce,
    output logic signed [COORD_BITS-1:0] o_min_x,
    output logic signed [COORD_BITS-1:0] o_min_y,
    output logic signed [COORD_BITS-1:0] o_max_x,
    output logic signed [COORD_BITS-1:0] o_max_y,
    output logic signed [COORD_BITS-1:0] o_vel_x,
    output logic signed [COORD_BITS-1:0] o_vel_y,
    output logic                         o_hit
);
    localparam int W = COORD_BITS;

    localparam logic signed [W+1:0] MAX_V = {3'b000, {(W-1){1'b1}}};
    localparam logic signed [W+1:0] MIN_V = {3'b111, {(W-1){1'b0}}};

    function automatic logic signed [W-1:0] sat_add(
        input logic signed [W-1:0] a,
        input logic signed [W+1:0] d
    );
        logic signed [W+1:0] sum;
        sum = $signed({{2{a[W-1]}}, a}) + d;
        if (sum > MAX_V) begin
            return MAX_V[W-1:0];
        end else if (sum < MIN_V) begin
            return MIN_V[W-1:0];
        end
        return sum[W-1:0];
    endfunction

    logic signed [W-1:0] lo_x, hi_x, lo_y, hi_y;
    logic signed [W:0]   ox, oy, sum_mx, sum_bx, sum_my, sum_by;
    logic signed [W+1:0] ox_e, oy_e, d_x, d_y;
    logic                push_x, below_x, below_y;

    always_comb begin
        o_hit = (i_mv_min_x < i_box_max_x) && (i_mv_max_x > i_box_min_x) &&
                (i_mv_min_y < i_box_max_y) && (i_mv_max_y > i_box_min_y);

        lo_x = (i_mv_min_x > i_box_min_x) ? i_mv_min_x : i_box_min_x;
        hi_x = (i_mv_max_x < i_box_max_x) ? i_mv_max_x : i_box_max_x;
        lo_y = (i_mv_min_y > i_box_min_y) ? i_mv_min_y : i_box_min_y;
        hi_y = (i_mv_max_y < i_box_max_y) ? i_mv_max_y : i_box_max_y;
        ox   = $signed({hi_x[W-1], hi_x}) - $signed({lo_x[W-1], lo_x});
        oy   = $signed({hi_y[W-1], hi_y}) - $signed({lo_y[W-1], lo_y});
        ox_e = $signed({ox[W], ox});
        oy_e = $signed({oy[W], oy});
        push_x = ox < oy;

        sum_mx = $signed({i_mv_min_x[W-1], i_mv_min_x}) + $signed({i_mv_max_x[W-1], i_mv_max_x});
        sum_bx = $signed({i_box_min_x[W-1], i_box_min_x})
               + $signed({i_box_max_x[W-1], i_box_max_x});
        sum_my = $signed({i_mv_min_y[W-1], i_mv_min_y}) + $signed({i_mv_max_y[W-1], i_mv_max_y});
        sum_by = $signed({i_box_min_y[W-1], i_box_min_y})
               + $signed({i_box_max_y[W-1], i_box_max_y});
        below_x = sum_mx < sum_bx;
        below_y = sum_my < sum_by;
        d_x = below_x ? -ox_e : ox_e;
        d_y = below_y ? -oy_e : oy_e;

        o_min_x = i_mv_min_x;
        o_max_x = i_mv_max_x;
        o_min_y = i_mv_min_y;
        o_max_y = i_mv_max_y;
        o_vel_x = i_mv_vel_x;
        o_vel_y = i_mv_vel_y;
        if (o_hit && push_x) begin
            o_min_x = sat_add(i_mv_min_x, d_x);
            o_max_x = sat_add(i_mv_max_x, d_x);
            o_vel_x = '0;
        end else if (o_hit) begin
            o_min_y = sat_add(i_mv_min_y, d_y);
            o_max_y = sat_add(i_mv_max_y, d_y);
            if (below_y) begin
                o_vel_y = '0;
            end else if (!i_mv_vel_y[W-1]) begin
                o_vel_y = i_bounce;
            end
        end
    end
endmodule

// ===== design/aabb_cr_touch.sv =====
// Contact detection of the pushed box against one static box within a skin.
// Depends on aabb_cr_pkg.
module aabb_cr_touch
    import aabb_cr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic signed [COORD_BITS-1:0] i_mv_min_x,
    input  logic signed [COORD_BITS-1:0] i_mv_min_y,
    input  logic signed [COORD_BITS-1:0] i_mv_max_x,
    input  logic signed [COORD_BITS-1:0] i_mv_max_y,
    input  logic signed [COORD_BITS-1:0] i_box_min_x,
    input  logic signed [COORD_BITS-1:0] i_box_min_y,
    input  logic signed [COORD_BITS-1:0] i_box_max_x,
    input  logic signed [COORD_BITS-1:0] i_box_max_y,
    input  logic        [SKIN_BITS-1:0]  i_skin,
    output t_flags                       o_touch
);
    localparam int W = COORD_BITS;

    logic signed [W:0] s, mnx, mny, mxx, mxy, bnx, bny, bxx, bxy;
    logic              ovx, ovy;

    always_comb begin
        s   = $signed({{(W+1-SKIN_BITS){1'b0}}, i_skin});
        mnx = $signed({i_mv_min_x[W-1], i_mv_min_x});
        mny = $signed({i_mv_min_y[W-1], i_mv_min_y});
        mxx = $signed({i_mv_max_x[W-1], i_mv_max_x});
        mxy = $signed({i_mv_max_y[W-1], i_mv_max_y});
        bnx = $signed({i_box_min_x[W-1], i_box_min_x});
        bny = $signed({i_box_min_y[W-1], i_box_min_y});
        bxx = $signed({i_box_max_x[W-1], i_box_max_x});
        bxy = $signed({i_box_max_y[W-1], i_box_max_y});

        ovx = (mxx + s > bnx) && (mnx - s < bxx);
        ovy = (mxy + s > bny) && (mny - s < bxy);

        o_touch.down  = ovx && (mxy >= bny - s) && (mxy <= bny + s);
        o_touch.up    = ovx && (mny >= bxy - s) && (mny <= bxy + s);
        o_touch.left  = ovy && (mnx >= bxx - s) && (mnx <= bxx + s);
        o_touch.right = ovy && (mxx >= bnx - s) && (mxx <= bnx + s);
    end
endmodule

// ===== design/aabb_collision_resolver_core.sv =====
// Box collision resolver: one item per clock unless a waiting result stalls a static item.
// A load item sets the moving box and velocity and clears the contact flags; it
// gives no result. Each static item gives one result with the box pushed out of
// the static box, the velocity and the accumulated flags. Items go into an input
// register; overlap test, push-out and contact test then run combinationally into
// the mover state and the result register, so the rate is set by that single
// path. A result waiting at the output does not hold back the next item until
// the input register is also full. No clearing pass follows reset.
// Depends on aabb_cr_pkg, both channel interfaces, aabb_cr_push, aabb_cr_touch.
`include "aabb_collision_resolver_core_defines.svh"

module aabb_collision_resolver_core
    import aabb_cr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [COORD_BITS-1:0] i_cfg_data,
    aabb_cr_in_if.sink            i_in,
    aabb_cr_out_if.source         o_out
);
    localparam int W = COORD_BITS;

    localparam longint SKIN_RESET_L = ((longint'(SKIN_NUM) << FRAC_BITS) + SKIN_DEN / 2)
                                      / SKIN_DEN;
    localparam logic [SKIN_BITS-1:0] SKIN_RESET = SKIN_RESET_L[SKIN_BITS-1:0];
    localparam longint BOUNCE_RAW = -(longint'(BOUNCE_SPEED) << FRAC_BITS);
    localparam longint BOUNCE_MIN = -(longint'(1) << (W - 1));
    localparam longint BOUNCE_L   = (BOUNCE_RAW < BOUNCE_MIN) ? BOUNCE_MIN : BOUNCE_RAW;
    localparam logic signed [W-1:0] BOUNCE_RESET = BOUNCE_L[W-1:0];

    logic [SKIN_BITS-1:0] r_skin;
    logic signed [W-1:0]  r_bounce;

    logic                r_s1_valid;
    t_opcode             r_s1_op;
    logic signed [W-1:0] r_s1_min_x, r_s1_min_y, r_s1_max_x, r_s1_max_y;
    logic signed [W-1:0] r_s1_vel_x, r_s1_vel_y;

    logic signed [W-1:0] r_mv_min_x, r_mv_min_y, r_mv_max_x, r_mv_max_y;
    logic signed [W-1:0] r_mv_vel_x, r_mv_vel_y;
    t_flags              r_flags;

    logic signed [W-1:0] n_mv_min_x, n_mv_min_y, n_mv_max_x, n_mv_max_y;
    logic signed [W-1:0] n_mv_vel_x, n_mv_vel_y;
    t_flags              n_flags;

    logic                r_out_valid;
    logic signed [W-1:0] r_out_min_x, r_out_min_y, r_out_max_x, r_out_max_y;
    logic signed [W-1:0] r_out_vel_x, r_out_vel_y;
    t_flags              r_out_flags;
    logic                r_out_hit;

    logic signed [W-1:0] w_min_x, w_min_y, w_max_x, w_max_y, w_vel_x, w_vel_y;
    logic                w_hit;
    t_flags              w_touch;
    logic                w_adv;
    logic                w_emit;

    aabb_cr_push #(
        .COORD_BITS (COORD_BITS)
    ) u_push (
        .i_mv_min_x  (r_mv_min_x),
        .i_mv_min_y  (r_mv_min_y),
        .i_mv_max_x  (r_mv_max_x),
        .i_mv_max_y  (r_mv_max_y),
        .i_mv_vel_x  (r_mv_vel_x),
        .i_mv_vel_y  (r_mv_vel_y),
        .i_box_min_x (r_s1_min_x),
        .i_box_min_y (r_s1_min_y),
        .i_box_max_x (r_s1_max_x),
        .i_box_max_y (r_s1_max_y),
        .i_bounce    (r_bounce),
        .o_min_x     (w_min_x),
        .o_min_y     (w_min_y),
        .o_max_x     (w_max_x),
        .o_max_y     (w_max_y),
        .o_vel_x     (w_vel_x),
        .o_vel_y     (w_vel_y),
        .o_hit       (w_hit)
    );

    aabb_cr_touch #(
        .COORD_BITS (COORD_BITS)
    ) u_touch (
        .i_mv_min_x  (w_min_x),
        .i_mv_min_y  (w_min_y),
        .i_mv_max_x  (w_max_x),
        .i_mv_max_y  (w_max_y),
        .i_box_min_x (r_s1_min_x),
        .i_box_min_y (r_s1_min_y),
        .i_box_max_x (r_s1_max_x),
        .i_box_max_y (r_s1_max_y),
        .i_skin      (r_skin),
        .o_touch     (w_touch)
    );

    assign w_adv  = r_s1_valid && (r_s1_op == OP_LOAD || !r_out_valid || o_out.ready);
    assign w_emit = w_adv && (r_s1_op == OP_STATIC);
    assign i_in.ready = !r_s1_valid || w_adv;

    always_comb begin
        unique case (r_s1_op)
            OP_LOAD: begin
                n_mv_min_x = r_s1_min_x;
                n_mv_min_y = r_s1_min_y;
                n_mv_max_x = r_s1_max_x;
                n_mv_max_y = r_s1_max_y;
                n_mv_vel_x = r_s1_vel_x;
                n_mv_vel_y = r_s1_vel_y;
                n_flags    = '0;
            end
            OP_STATIC: begin
                n_mv_min_x = w_min_x;
                n_mv_min_y = w_min_y;
                n_mv_max_x = w_max_x;
                n_mv_max_y = w_max_y;
                n_mv_vel_x = w_vel_x;
                n_mv_vel_y = w_vel_y;
                n_flags    = t_flags'(r_flags | w_touch);
            end
            default: begin
                n_mv_min_x = r_mv_min_x;
                n_mv_min_y = r_mv_min_y;
                n_mv_max_x = r_mv_max_x;
                n_mv_max_y = r_mv_max_y;
                n_mv_vel_x = r_mv_vel_x;
                n_mv_vel_y = r_mv_vel_y;
                n_flags    = r_flags;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skin   <= SKIN_RESET;
            r_bounce <= BOUNCE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SKIN_WIDTH: r_skin   <= i_cfg_data[SKIN_BITS-1:0];
                CFG_BOUNCE_VEL: r_bounce <= $signed(i_cfg_data[W-1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_op    <= i_in.opcode;
            r_s1_min_x <= i_in.box_min_x;
            r_s1_min_y <= i_in.box_min_y;
            r_s1_max_x <= i_in.box_max_x;
            r_s1_max_y <= i_in.box_max_y;
            r_s1_vel_x <= i_in.load_vel_x;
            r_s1_vel_y <= i_in.load_vel_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv_min_x <= '0;
            r_mv_min_y <= '0;
            r_mv_max_x <= '0;
            r_mv_max_y <= '0;
            r_mv_vel_x <= '0;
            r_mv_vel_y <= '0;
            r_flags    <= '0;
        end else if (w_adv) begin
            r_mv_min_x <= n_mv_min_x;
            r_mv_min_y <= n_mv_min_y;
            r_mv_max_x <= n_mv_max_x;
            r_mv_max_y <= n_mv_max_y;
            r_mv_vel_x <= n_mv_vel_x;
            r_mv_vel_y <= n_mv_vel_y;
            r_flags    <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_min_x <= n_mv_min_x;
            r_out_min_y <= n_mv_min_y;
            r_out_max_x <= n_mv_max_x;
            r_out_max_y <= n_mv_max_y;
            r_out_vel_x <= n_mv_vel_x;
            r_out_vel_y <= n_mv_vel_y;
            r_out_flags <= n_flags;
            r_out_hit   <= w_hit;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_min_x   = r_out_min_x;
    assign o_out.out_min_y   = r_out_min_y;
    assign o_out.out_max_x   = r_out_max_x;
    assign o_out.out_max_y   = r_out_max_y;
    assign o_out.out_vel_x   = r_out_vel_x;
    assign o_out.out_vel_y   = r_out_vel_y;
    assign o_out.touch_down  = r_out_flags.down;
    assign o_out.touch_up    = r_out_flags.up;
    assign o_out.touch_left  = r_out_flags.left;
    assign o_out.touch_right = r_out_flags.right;
    assign o_out.collided    = r_out_hit;

    // A new result only ever comes from a static item leaving the input register.
    `AABB_CR_ASSERT(a_result_from_static, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(w_emit))
    // A load leaves the contact flags clear.
    `AABB_CR_ASSERT(a_load_clears_flags, i_clk, i_rst_n, (w_adv && r_s1_op == OP_LOAD) |=> (r_flags == '0))
    // Between loads the contact flags only accumulate.
    `AABB_CR_ASSERT(a_flags_sticky, i_clk, i_rst_n, (w_adv && r_s1_op == OP_STATIC) |=> ((r_flags & $past(r_flags)) == $past(r_flags)))
    // An accepted transfer always lands in the input register.
    `AABB_CR_ASSERT(a_accept_fills_s1, i_clk, i_rst_n, (i_in.valid && i_in.ready) |=> r_s1_valid)
    // Reset leaves no result pending.
    `AABB_CR_ASSERT_NR(a_reset_empties_out, i_clk, !i_rst_n |=> !r_out_valid)
endmodule

// ===== test/tb_aabb_cr_checker.sv =====
// Result checker for the box collision resolver: tracks the moving box from every
// input transfer and compares each result transfer with the state it predicts.
// Depends on aabb_cr_pkg and both channel interfaces.
module aabb_cr_result_checker
    import aabb_cr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [COORD_BITS-1:0] i_cfg_data,
    aabb_cr_in_if                 i_in,
    aabb_cr_out_if                i_out,
    output int                    o_fail_count,
    output int                    o_outstanding
);

    localparam longint CMAX = (longint'(1) << (COORD_BITS - 1)) - 1;
    localparam longint CMIN = -CMAX - 1;
    localparam longint SKIN_RESET =
        (((longint'(SKIN_NUM) << FRAC_BITS) + SKIN_DEN / 2) / SKIN_DEN) & 255;
    localparam longint BOUNCE_RAW   = -(longint'(BOUNCE_SPEED) << FRAC_BITS);
    localparam longint BOUNCE_RESET = (BOUNCE_RAW < CMIN) ? CMIN : BOUNCE_RAW;

    typedef struct {
        logic signed [COORD_BITS-1:0] min_x;
        logic signed [COORD_BITS-1:0] min_y;
        logic signed [COORD_BITS-1:0] max_x;
        logic signed [COORD_BITS-1:0] max_y;
        logic signed [COORD_BITS-1:0] vel_x;
        logic signed [COORD_BITS-1:0] vel_y;
        t_flags                       flags;
        logic                         collided;
    } t_mover_state;

    longint       mv_min_x, mv_min_y, mv_max_x, mv_max_y, mv_vel_x, mv_vel_y;
    t_flags       contacts;
    longint       skin_width, bounce_vel;
    t_mover_state resolved_states[$];
    int           fail_count = 0;
    int           outstanding = 0;

    assign o_fail_count  = fail_count;
    assign o_outstanding = outstanding;

    function automatic longint clip(longint v);
        if (v > CMAX) return CMAX;
        if (v < CMIN) return CMIN;
        return v;
    endfunction

    function automatic bit near_edge(longint v, longint e, longint s);
        return v >= e - s && v <= e + s;
    endfunction

    task automatic report_error(string msg);
        $display("%0t checker: %s", $time, msg);
        fail_count++;
    endtask

    task automatic compare_field(string name, longint got, longint want);
        if (got != want)
            report_error($sformatf("%s got %0d, predicted %0d", name, got, want));
    endtask

    task automatic resolve_item(t_opcode op, longint x0, longint y0, longint x1,
                                longint y1, longint vx, longint vy);
        bit           hit, ovx, ovy;
        longint       ox, oy, d, s;
        t_mover_state st;
        if (op == OP_LOAD) begin
            mv_min_x = x0;
            mv_min_y = y0;
            mv_max_x = x1;
            mv_max_y = y1;
            mv_vel_x = vx;
            mv_vel_y = vy;
            contacts = '0;
            return;
        end
        hit = mv_min_x < x1 && mv_max_x > x0 && mv_min_y < y1 && mv_max_y > y0;
        if (hit) begin
            ox = ((mv_max_x < x1) ? mv_max_x : x1) - ((mv_min_x > x0) ? mv_min_x : x0);
            oy = ((mv_max_y < y1) ? mv_max_y : y1) - ((mv_min_y > y0) ? mv_min_y : y0);
            if (ox < oy) begin
                d = (mv_min_x + mv_max_x < x0 + x1) ? -ox : ox;
                mv_min_x = clip(mv_min_x + d);
                mv_max_x = clip(mv_max_x + d);
                mv_vel_x = 0;
            end else begin
                if (mv_min_y + mv_max_y < y0 + y1) begin
                    d = -oy;
                    mv_vel_y = 0;
                end else begin
                    d = oy;
                    if (mv_vel_y >= 0) mv_vel_y = bounce_vel;
                end
                mv_min_y = clip(mv_min_y + d);
                mv_max_y = clip(mv_max_y + d);
            end
        end
        s = skin_width;
        ovx = (mv_max_x + s > x0) && (mv_min_x - s < x1);
        ovy = (mv_max_y + s > y0) && (mv_min_y - s < y1);
        if (ovx && near_edge(mv_max_y, y0, s)) contacts.down = 1'b1;
        if (ovx && near_edge(mv_min_y, y1, s)) contacts.up = 1'b1;
        if (ovy && near_edge(mv_min_x, x1, s)) contacts.left = 1'b1;
        if (ovy && near_edge(mv_max_x, x0, s)) contacts.right = 1'b1;
        st.min_x    = mv_min_x[COORD_BITS-1:0];
        st.min_y    = mv_min_y[COORD_BITS-1:0];
        st.max_x    = mv_max_x[COORD_BITS-1:0];
        st.max_y    = mv_max_y[COORD_BITS-1:0];
        st.vel_x    = mv_vel_x[COORD_BITS-1:0];
        st.vel_y    = mv_vel_y[COORD_BITS-1:0];
        st.flags    = contacts;
        st.collided = hit;
        resolved_states.push_back(st);
    endtask

    task automatic check_result();
        t_mover_state want;
        if (resolved_states.size() == 0) begin
            report_error("result transfer with no result outstanding");
            return;
        end
        want = resolved_states.pop_front();
        compare_field("out_min_x", i_out.out_min_x, want.min_x);
        compare_field("out_min_y", i_out.out_min_y, want.min_y);
        compare_field("out_max_x", i_out.out_max_x, want.max_x);
        compare_field("out_max_y", i_out.out_max_y, want.max_y);
        compare_field("out_vel_x", i_out.out_vel_x, want.vel_x);
        compare_field("out_vel_y", i_out.out_vel_y, want.vel_y);
        compare_field("touch_down", i_out.touch_down, want.flags.down);
        compare_field("touch_up", i_out.touch_up, want.flags.up);
        compare_field("touch_left", i_out.touch_left, want.flags.left);
        compare_field("touch_right", i_out.touch_right, want.flags.right);
        compare_field("collided", i_out.collided, want.collided);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mv_min_x   = 0;
            mv_min_y   = 0;
            mv_max_x   = 0;
            mv_max_y   = 0;
            mv_vel_x   = 0;
            mv_vel_y   = 0;
            contacts   = '0;
            skin_width = SKIN_RESET;
            bounce_vel = BOUNCE_RESET;
            resolved_states.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SKIN_WIDTH: skin_width = i_cfg_data[SKIN_BITS-1:0];
                    CFG_BOUNCE_VEL: bounce_vel = $signed(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) check_result();
            if (i_in.valid && i_in.ready)
                resolve_item(i_in.opcode, i_in.box_min_x, i_in.box_min_y, i_in.box_max_x,
                             i_in.box_max_y, i_in.load_vel_x, i_in.load_vel_y);
        end
        outstanding = resolved_states.size();
    end

endmodule

// ===== test/tb_aabb_collision_resolver_core.sv =====
// Testbench top for the box collision resolver: drives directed and random box
// streams under varied handshake pressure and gives the verdict.
// Depends on aabb_cr_pkg, both channel interfaces, the core and the result checker.
module tb_aabb_collision_resolver_core;
    import aabb_cr_pkg::*;

    localparam int     CW          = COORD_BITS_DEF;
    localparam longint CMAX        = (longint'(1) << (CW - 1)) - 1;
    localparam longint CMIN        = -CMAX - 1;
    localparam int     HOLD_CYCLES = 300;
    localparam longint RUN_LIMIT   = 12 * 200000;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_we;
    t_cfg_idx        i_cfg_idx;
    logic [CW-1:0]   i_cfg_data;
    logic            in_fire = 1'b0;
    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;
    bit              pressure_on = 1'b0;
    bit              hold_done = 1'b0;
    int              fail_count;
    int              outstanding;

    aabb_cr_in_if  in_ch ();
    aabb_cr_out_if out_ch ();

    aabb_collision_resolver_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    aabb_cr_result_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        in_fire <= in_ch.valid && in_ch.ready;
    end

    // The receiver holds off once for a long stretch when the pressure phase starts.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (pressure_on && !hold_done) begin
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("aabb_collision_resolver_core: mismatch");
        $finish;
    end

    function automatic logic signed [CW-1:0] clamp_coord(longint v);
        longint c;
        c = v;
        if (c > CMAX) c = CMAX;
        if (c < CMIN) c = CMIN;
        return c[CW-1:0];
    endfunction

    function automatic longint rand_coord();
        logic [31:0]          r;
        logic signed [CW-1:0] v;
        r = $urandom;
        v = r[CW-1:0];
        return v;
    endfunction

    function automatic longint spread(int span);
        return longint'($urandom_range(2 * span)) - span;
    endfunction

    function automatic longint pick_centre();
        case ($urandom_range(7))
            0: return CMAX - longint'($urandom_range(5000));
            1: return CMIN + longint'($urandom_range(5000));
            default: return spread(1 << 20);
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(t_opcode op, longint x0, longint y0, longint x1, longint y1,
                             longint vx, longint vy);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid      = 1'b1;
        in_ch.opcode     = op;
        in_ch.box_min_x  = clamp_coord(x0);
        in_ch.box_min_y  = clamp_coord(y0);
        in_ch.box_max_x  = clamp_coord(x1);
        in_ch.box_max_y  = clamp_coord(y1);
        in_ch.load_vel_x = clamp_coord(vx);
        in_ch.load_vel_y = clamp_coord(vy);
        do @(negedge i_clk); while (!in_fire);
    endtask

    task automatic write_cfg(t_cfg_idx idx, longint value);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value[CW-1:0];
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    task automatic drain(int settle);
        in_ch.valid = 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic random_burst(int n_items);
        int     sent, statics, w, h;
        longint cx, cy, mx0, my0, mx1, my1, sx0, sy0, sx1, sy1, t;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                send_item(($urandom_range(1) == 1) ? OP_STATIC : OP_LOAD, rand_coord(),
                          rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                          rand_coord());
                sent++;
            end else begin
                cx  = pick_centre();
                cy  = pick_centre();
                w   = $urandom_range(2048, 1);
                h   = $urandom_range(2048, 1);
                mx0 = clamp_coord(cx - w / 2);
                mx1 = clamp_coord(cx + w / 2);
                my0 = clamp_coord(cy - h / 2);
                my1 = clamp_coord(cy + h / 2);
                send_item(OP_LOAD, mx0, my0, mx1, my1, rand_coord(), rand_coord());
                statics = $urandom_range(12, 2);
                repeat (statics) begin
                    sx0 = mx0 + spread(w);
                    sx1 = sx0 + longint'($urandom_range(2 * w, 1));
                    sy0 = my0 + spread(h);
                    sy1 = sy0 + longint'($urandom_range(2 * h, 1));
                    case ($urandom_range(6))
                        0: begin
                            sx0 = mx1 + spread(300);
                            sx1 = sx0 + longint'($urandom_range(2 * w, 1));
                        end
                        1: begin
                            sx1 = mx0 + spread(300);
                            sx0 = sx1 - longint'($urandom_range(2 * w, 1));
                        end
                        2: begin
                            sy0 = my1 + spread(300);
                            sy1 = sy0 + longint'($urandom_range(2 * h, 1));
                        end
                        3: begin
                            sy1 = my0 + spread(300);
                            sy0 = sy1 - longint'($urandom_range(2 * h, 1));
                        end
                        4: begin
                            t   = sx0;
                            sx0 = sx1;
                            sx1 = t;
                        end
                        default: ;
                    endcase
                    send_item(OP_STATIC, sx0, sy0, sx1, sy1, rand_coord(), rand_coord());
                end
                sent += statics + 1;
            end
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_SKIN_WIDTH;
        i_cfg_data       = '0;
        in_ch.valid      = 1'b0;
        in_ch.opcode     = OP_LOAD;
        in_ch.box_min_x  = '0;
        in_ch.box_min_y  = '0;
        in_ch.box_max_x  = '0;
        in_ch.box_max_y  = '0;
        in_ch.load_vel_x = '0;
        in_ch.load_vel_y = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // A static box before any load meets the all-zero reset box.
        send_item(OP_STATIC, -16, -16, 16, 16, 0, 0);
        send_item(OP_LOAD, 0, 0, 256, 256, 100, 50);
        send_item(OP_STATIC, 200, 0, 600, 256, 0, 0);
        send_item(OP_STATIC, -300, 0, -20, 256, 0, 0);
        send_item(OP_STATIC, -20, 200, 236, 500, 0, 0);
        send_item(OP_STATIC, -20, -400, 236, -30, 0, 0);
        // An upward push keeps a negative vertical velocity.
        send_item(OP_LOAD, 0, 0, 100, 100, -5, -300);
        send_item(OP_STATIC, 0, -50, 100, 20, 0, 0);
        // Equal overlaps resolve along Y; then a near miss inside the skin.
        send_item(OP_LOAD, 0, 0, 100, 100, 0, 0);
        send_item(OP_STATIC, 50, 50, 150, 150, 0, 0);
        send_item(OP_STATIC, 104, -50, 300, 50, 0, 0);
        // Pushes against both ends of the range saturate one corner.
        send_item(OP_LOAD, CMAX - 100, 0, CMAX, 100, CMAX, CMIN);
        send_item(OP_STATIC, CMAX - 300, 0, CMAX - 60, 100, 0, 0);
        send_item(OP_LOAD, CMIN, 0, CMIN + 100, 100, CMIN, CMAX);
        send_item(OP_STATIC, CMIN + 40, 0, CMIN + 300, 100, 0, 0);
        send_item(OP_LOAD, CMIN, CMIN, CMAX, CMAX, CMIN, CMAX);
        send_item(OP_STATIC, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN);
        send_item(OP_STATIC, CMAX, CMAX, CMAX, CMAX, 0, 0);
        send_item(OP_STATIC, CMIN, CMIN, CMIN, CMIN, 0, 0);
        // Inverted boxes, moving and static.
        send_item(OP_LOAD, 100, 100, 0, 0, 7, 9);
        send_item(OP_STATIC, -50, -50, 50, 50, 0, 0);
        send_item(OP_LOAD, 0, 0, 100, 100, 7, 9);
        send_item(OP_STATIC, 80, 80, 20, 20, 0, 0);

        for (int phase = 0; phase < 5; phase++) begin
            drain(4);
            case (phase)
                0: begin
                    write_cfg(CFG_SKIN_WIDTH, 0);
                    write_cfg(CFG_BOUNCE_VEL, CMIN);
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    write_cfg(CFG_SKIN_WIDTH, 255);
                    write_cfg(CFG_BOUNCE_VEL, CMAX);
                    send_idle_pct  = 45;
                    recv_stall_pct = 0;
                end
                2: begin
                    write_cfg(CFG_SKIN_WIDTH, 8);
                    write_cfg(CFG_BOUNCE_VEL, 0);
                    send_idle_pct  = 0;
                    recv_stall_pct = 45;
                end
                3: begin
                    write_cfg(CFG_SKIN_WIDTH, $urandom_range(255));
                    write_cfg(CFG_BOUNCE_VEL, rand_coord());
                    send_idle_pct  = 36;
                    recv_stall_pct = 36;
                end
                default: begin
                    write_cfg(CFG_SKIN_WIDTH, $urandom_range(255));
                    write_cfg(CFG_BOUNCE_VEL, -25600);
                    send_idle_pct  = 0;
                    recv_stall_pct = 20;
                    pressure_on    = 1'b1;
                end
            endcase
            random_burst(330);
        end

        drain(10);
        if (fail_count == 0) begin
            $display("aabb_collision_resolver_core: match");
        end else begin
            $display("aabb_collision_resolver_core: mismatch");
        end
        $finish;
    end

endmodule
